@@ hdl/aes_pkg.sv @@
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  typedef struct packed {
    logic [63:0] plaintext_high;
    logic [63:0] plaintext_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;
  } aes_out_t;

  typedef enum logic [7:0] {
    RegKeyHigh = 8'd0,
    RegKeyLow  = 8'd1
  } aes_reg_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
  };

  localparam logic [7:0] GfPoly = 8'h1B;

  // Byte i of a 128-bit block sits at bits 127-8i down to 120-8i.
  function automatic logic [7:0] get_byte(logic [127:0] s, int unsigned i);
    get_byte = s[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] gf_double(logic [7:0] v);
    gf_double = {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = get_byte(s, 4*c);
      a1  = get_byte(s, 4*c + 1);
      a2  = get_byte(s, 4*c + 2);
      a3  = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c)     -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
      t[127 - 8*(4*c + 1) -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
      t[127 - 8*(4*c + 2) -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
      t[127 - 8*(4*c + 3) -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

  function automatic logic [127:0] next_key(logic [127:0] k, logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

@@ hdl/aes_round.sv @@
`default_nettype none
module aes_round import aes_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic [7:0]   rcon_i,
  input  wire logic         last_i,
  input  wire logic         valid_i,
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] key_i,
  output logic              valid_o,
  output logic [127:0]      state_o,
  output logic [127:0]      key_o
);

  logic         valid_q;
  logic [127:0] state_q, state_d, key_q, key_d, sub_state;

  always_comb begin
    key_d     = next_key(key_i, rcon_i);
    sub_state = sub_shift(state_i);
    state_d   = (last_i ? sub_state : mix_cols(sub_state)) ^ key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Hold payload while the pipeline is frozen.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule
`default_nettype wire

@@ hdl/aes128_block_encrypt_core.sv @@
// AES-128 encryption core, one fully unrolled round per pipeline stage.
//
// Input channel: in_valid_i / in_stall_o carry a plaintext block (in_data_i).
// Output channel: out_valid_o / out_stall_i carry the ciphertext (out_data_o).
// A transaction completes on a rising edge with valid high and stall low.
// Configuration: cfg_valid_i / cfg_ready_o write cfg_data_i to register
// cfg_index_i (0 = key high, 1 = key low); other indexes are dropped.
// cfg_ready_o is always high. Change the key only while the core is empty.
//
// out_valid_o rises once the input block has passed through
// eleven register stages (one for the initial key add, then ten round
// stages, the last being the output register). Throughput: one block per
// cycle unless a held-back result freezes the pipeline. Each stage carries
// its own round key, expanded on the fly next to the data round.
//
// Reset clears the key and all stage valid bits. When the receiver stalls
// with a result pending, every stage holds, bubbles included, and in_stall_o
// rises in the same cycle.
`default_nettype none
module aes128_block_encrypt_core import aes_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire aes_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output aes_out_t        out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  logic [63:0]  key_high_q, key_low_q;
  logic         advance;
  logic         valid_s [NumRounds + 1];
  logic [127:0] state_s [NumRounds + 1];
  logic [127:0] key_s   [NumRounds + 1];
  logic         v0_q;
  logic [127:0] st0_q, k0_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegKeyHigh: key_high_q <= cfg_data_i;
        RegKeyLow:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Freeze every stage only when a finished result is held back.
  assign advance    = !(valid_s[NumRounds] && out_stall_i);
  assign in_stall_o = !advance;

  // Stage 0: initial round key add.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (advance) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      st0_q <= {in_data_i.plaintext_high, in_data_i.plaintext_low}
               ^ {key_high_q, key_low_q};
      k0_q  <= {key_high_q, key_low_q};
    end
  end

  assign valid_s[0] = v0_q;
  assign state_s[0] = st0_q;
  assign key_s[0]   = k0_q;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    aes_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .rcon_i  (RCON[r]),
      .last_i  (r == NumRounds - 1),
      .valid_i (valid_s[r]),
      .state_i (state_s[r]),
      .key_i   (key_s[r]),
      .valid_o (valid_s[r + 1]),
      .state_o (state_s[r + 1]),
      .key_o   (key_s[r + 1])
    );
  end

  assign out_valid_o                = valid_s[NumRounds];
  assign out_data_o.ciphertext_high = state_s[NumRounds][127:64];
  assign out_data_o.ciphertext_low  = state_s[NumRounds][63:0];

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the AES-128 encryption core.
// Drive plaintext blocks through several stall/idle phases and key settings,
// predict each ciphertext locally and compare it field by field.

class cipher_scoreboard;
  logic [63:0] key_hi, key_lo;
  aes_pkg::aes_out_t pending_ct[$];
  int unsigned errors;
  int unsigned checked;

  function new();
    key_hi = '0;
    key_lo = '0;
    errors = 0;
    checked = 0;
  endfunction

  function automatic logic [7:0] sbox_lookup(logic [7:0] b);
    sbox_lookup = aes_pkg::SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  // Encrypt one block using byte arrays, column-major.
  function automatic aes_pkg::aes_out_t encrypt(aes_pkg::aes_in_t pt);
    logic [7:0] rk[176];
    logic [7:0] st[16];
    logic [7:0] tmp[16];
    logic [7:0] w[4];
    logic [7:0] f, a0, a1, a2, a3, al;
    aes_pkg::aes_out_t ct;
    for (int i = 0; i < 8; i++) begin
      rk[i] = key_hi[63 - 8*i -: 8];
      rk[8 + i] = key_lo[63 - 8*i -: 8];
      st[i] = pt.plaintext_high[63 - 8*i -: 8];
      st[8 + i] = pt.plaintext_low[63 - 8*i -: 8];
    end
    for (int p = 16; p < 176; p += 4) begin
      for (int i = 0; i < 4; i++) w[i] = rk[p - 4 + i];
      if (p % 16 == 0) begin
        f = w[0];
        w[0] = sbox_lookup(w[1]) ^ aes_pkg::RCON[p/16 - 1];
        w[1] = sbox_lookup(w[2]);
        w[2] = sbox_lookup(w[3]);
        w[3] = sbox_lookup(f);
      end
      for (int i = 0; i < 4; i++) rk[p + i] = rk[p - 16 + i] ^ w[i];
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) tmp[4*c + r] = sbox_lookup(st[4*((c + r) % 4) + r]);
      st = tmp;
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c + 1]; a2 = st[4*c + 2]; a3 = st[4*c + 3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]     = a0 ^ al ^ xtime(a0 ^ a1);
          st[4*c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
          st[4*c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
          st[4*c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[16*rnd + i];
    end
    for (int i = 0; i < 8; i++) begin
      ct.ciphertext_high[63 - 8*i -: 8] = st[i];
      ct.ciphertext_low[63 - 8*i -: 8] = st[8 + i];
    end
    return ct;
  endfunction

  function void write_key(logic [7:0] idx, logic [63:0] val);
    if (idx == aes_pkg::RegKeyHigh) key_hi = val;
    else if (idx == aes_pkg::RegKeyLow) key_lo = val;
  endfunction

  function void note_plaintext(aes_pkg::aes_in_t pt);
    pending_ct.push_back(encrypt(pt));
  endfunction

  function void check_ciphertext(aes_pkg::aes_out_t got);
    aes_pkg::aes_out_t exp_ct;
    if (pending_ct.size() == 0) begin
      $error("ciphertext with no block outstanding: %h", got);
      errors++;
      return;
    end
    exp_ct = pending_ct.pop_front();
    checked++;
    if (got.ciphertext_high !== exp_ct.ciphertext_high) begin
      $error("ciphertext_high expected %h actual %h", exp_ct.ciphertext_high,
             got.ciphertext_high);
      errors++;
    end
    if (got.ciphertext_low !== exp_ct.ciphertext_low) begin
      $error("ciphertext_low expected %h actual %h", exp_ct.ciphertext_low,
             got.ciphertext_low);
      errors++;
    end
  endfunction
endclass

module testbench;
  import aes_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  aes_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  aes_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  // Percent chance per cycle of the sender idling / receiver stalling.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // Cycles of forced receiver hold-off, counted down by the sink process.
  int unsigned hold_cycles = 0;

  cipher_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  aes128_block_encrypt_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Sink: check every transaction on the output side, then pick next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_ciphertext(out_data_o);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Write one key register while the pipeline is empty.
  task automatic write_reg(aes_reg_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_key(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write to an unmapped index: must be dropped.
  task automatic write_bad_index(logic [7:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one block; hold it until the transaction completes.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{plaintext_high: hi, plaintext_low: lo};
    do @(posedge clk_i); while (in_stall_o);
    sb.note_plaintext(in_data_i);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
  endtask

  // Pause until every outstanding ciphertext has come back.
  task automatic drain();
    go_idle();
    while (sb.pending_ct.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Sparse or dense patterns so each bit sees both values in many mixes.
  function automatic logic [63:0] pattern64();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      3: return ~(64'd1 << $urandom_range(63));
      default: return rand64();
    endcase
  endfunction

  task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_block(pattern64(), pattern64());
      else send_block(rand64(), rand64());
    end
    drain();
  endtask

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key of zero, then the FIPS-197 appendix key.
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    drain();
    write_reg(RegKeyHigh, 64'h0001_0203_0405_0607);
    write_reg(RegKeyLow, 64'h0809_0a0b_0c0d_0e0f);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block('0, '1);
    send_block('1, '0);
    drain();
    // Unmapped index must leave the key alone.
    write_bad_index(8'd2, '1);
    write_bad_index(8'hFF, 64'h1234_5678_9abc_def0);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    drain();
    write_reg(RegKeyHigh, '1);
    write_reg(RegKeyLow, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();
    // Key change takes effect on the next block: switch only one half.
    write_reg(RegKeyLow, '0);
    send_block('0, '0);
    send_block(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c);

    // Long receiver hold-off with the sender still offering: fill the
    // pipeline until the input stalls.
    recv_stall_pct = 0;
    send_idle_pct = 0;
    hold_cycles = 40;
    for (int i = 0; i < 16; i++) send_block(rand64(), rand64());
    drain();

    // Random phases, each under a fresh key.
    write_reg(RegKeyHigh, rand64());
    write_reg(RegKeyLow, rand64());
    random_phase(500, 0, 0);
    write_reg(RegKeyHigh, rand64());
    write_reg(RegKeyLow, rand64());
    random_phase(480, 55, 0);
    write_reg(RegKeyHigh, '0);
    write_reg(RegKeyLow, rand64());
    random_phase(480, 0, 55);
    write_reg(RegKeyHigh, rand64());
    write_reg(RegKeyLow, '1);
    random_phase(460, 38, 38);

    repeat (20) @(posedge clk_i);
    $display("Encrypted %0d blocks under several keys, across idle and stall mixes.",
             sb.checked);
    if (sb.errors == 0 && sb.pending_ct.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
